[sv/satc_pkg.sv]
// Shared constants and types of the set-associative cache tag controller.
`default_nettype none

package satc_pkg;

  // Default geometry.
  localparam int DefSets = 64;
  localparam int DefWays = 8;

  // Field widths.
  localparam int AddrW    = 32;
  localparam int TagW     = 32;
  localparam int StampW   = 32;
  localparam int SizeW    = 4;
  localparam int WayOutW  = 3;
  localparam int SetOutW  = 6;
  // A set number has at most as many bits as the largest index_bits value.
  localparam int SetW     = 7;
  localparam int BlkW     = 8;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CFG_OFFSET_BITS    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INDEX_BITS     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WAYS_USED      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REPLACE_POLICY = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_POLICY   = 3'd4;

  localparam logic [2:0] RST_OFFSET_BITS = 3'd4;
  localparam logic [2:0] RST_INDEX_BITS  = 3'd6;
  localparam logic [3:0] RST_WAYS_USED   = 4'd8;

  // Replacement and write policies.
  localparam logic [1:0] POL_LRU    = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;
  localparam logic       WP_WB      = 1'b0;
  localparam logic       WP_WT      = 1'b1;
  localparam logic       CMD_READ   = 1'b0;
  localparam logic       CMD_WRITE  = 1'b1;

  // Victim randomizer.
  localparam int              LfsrW    = 16;
  localparam logic [LfsrW-1:0] LFSR_SEED = 16'hACE1;
  localparam int              ModStep  = 4;
  localparam int              ModCycles = LfsrW / ModStep;

  // One line of a set as it sits in the set memory.
  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [TagW-1:0]   tag;
    logic [StampW-1:0] order;
  } line_t;

  // One result beat.
  typedef struct packed {
    logic               hit;
    logic               error;
    logic [WayOutW-1:0] way;
    logic [SetOutW-1:0] set_index;
    logic [TagW-1:0]    tag_value;
    logic               line_dirty;
    logic               writeback_valid;
    logic [AddrW-1:0]   writeback_addr;
    logic               fill_valid;
    logic               mem_write_valid;
  } result_t;

endpackage

`default_nettype wire

[sv/set_assoc_cache_tag_controller.sv]
// Tag, valid, dirty and replacement controller of a set-associative cache.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------------------
//   access   | cmd_i addr_i size_i                     | taken when start=1 and busy=0
//   result   | hit_o error_o way_o ... mem_write_valid_o | one cycle, marked by done_o
//   config   | cfg_idx_i cfg_data_i                    | written when cfg_we_i=1
//
// In an access, the set row is first read from the set memory, then the
// row is updated and written back while the result is registered. A miss that
// evicts at random from a full set also passes through ST_MOD, where the randomizer value
// is reduced modulo the ways in use 4 bits per cycle.
// After reset, a clearing pass writes every row of the set memory, one per
// cycle, with busy high. The result beat cannot be stalled;
// the next access may be taken in the same cycle a result beat is shown.
`default_nettype none

module set_assoc_cache_tag_controller #(
  parameter int SETS = satc_pkg::DefSets,
  parameter int WAYS = satc_pkg::DefWays
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Access beat.
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic                          cmd_i,
  input  wire logic [satc_pkg::AddrW-1:0]    addr_i,
  input  wire logic [satc_pkg::SizeW-1:0]    size_i,
  // Configuration writes.
  input  wire logic                          cfg_we_i,
  input  wire logic [satc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [satc_pkg::CfgDataW-1:0] cfg_data_i,
  // Result beat.
  output      logic                          done_o,
  output      logic                          hit_o,
  output      logic                          error_o,
  output      logic [satc_pkg::WayOutW-1:0]  way_o,
  output      logic [satc_pkg::SetOutW-1:0]  set_index_o,
  output      logic [satc_pkg::TagW-1:0]     tag_value_o,
  output      logic                          line_dirty_o,
  output      logic                          writeback_valid_o,
  output      logic [satc_pkg::AddrW-1:0]    writeback_addr_o,
  output      logic                          fill_valid_o,
  output      logic                          mem_write_valid_o
);
  import satc_pkg::*;

  localparam int SetLog = $clog2(SETS + 1) - 1;           // floor(log2(SETS))
  localparam int SaW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WiW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NwW    = $clog2(WAYS + 1);
  localparam int RemW   = NwW + 1;
  localparam int TreeP  = 1 << $clog2(WAYS);
  localparam int McW    = (ModCycles > 1) ? $clog2(ModCycles) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_MOD
  } state_e;

  typedef struct packed {
    logic              en;
    logic [StampW-1:0] ord;
    logic [WiW-1:0]    idx;
  } node_t;

  // Configuration registers.
  logic [2:0] cfg_ob_q, cfg_ib_q;
  logic [3:0] cfg_ways_q;
  logic [1:0] cfg_pol_q;
  logic       cfg_wp_q;

  state_e             state_q;
  logic [SaW-1:0]     clr_q;
  logic               cmd_q, err_q;
  logic [SetW-1:0]    set_q;
  logic [TagW-1:0]    tag_q;
  logic [StampW-1:0]  cnt_q;
  logic [LfsrW-1:0]   lfsr_q, modx_q;
  logic [RemW-1:0]    rem_q;
  logic [McW-1:0]     mcnt_q;
  logic               done_q;
  result_t            res_q;

  // Set memory: one row of WAYS lines per set, read data registered.
  line_t [WAYS-1:0]   set_mem [SETS];
  line_t [WAYS-1:0]   rd_q;

  // Effective configuration.
  logic [2:0]     ib_eff;
  logic [NwW-1:0] nw;

  always_comb begin
    if (int'(cfg_ib_q) > SetLog) ib_eff = 3'(SetLog);
    else                         ib_eff = cfg_ib_q;
    if (cfg_ways_q == 4'd0)            nw = NwW'(1);
    else if (int'(cfg_ways_q) > WAYS)  nw = NwW'(WAYS);
    else                               nw = NwW'(cfg_ways_q);
  end

  // Address split of an incoming access.
  logic             accept;
  logic [AddrW-1:0] acc_set, acc_tag;
  logic [BlkW-1:0]  acc_blk, acc_off;
  logic             acc_err;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    acc_set = (addr_i >> cfg_ob_q) & ~({AddrW{1'b1}} << ib_eff);
    acc_tag = addr_i >> ({1'b0, cfg_ob_q} + {1'b0, ib_eff});
    acc_blk = BlkW'(1) << cfg_ob_q;
    acc_off = addr_i[BlkW-1:0] & (acc_blk - BlkW'(1));
    acc_err = (acc_blk - acc_off) < {{(BlkW-SizeW){1'b0}}, size_i};
  end

  // Tag match and first invalid way.
  logic           hit, inv_found;
  logic [WiW-1:0] hit_w, inv_w;

  always_comb begin
    hit       = 1'b0;
    hit_w     = '0;
    inv_found = 1'b0;
    inv_w     = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (w < int'(nw)) begin
        if (rd_q[w].valid && rd_q[w].tag == tag_q) begin
          hit   = 1'b1;
          hit_w = WiW'(w);
        end
        if (!rd_q[w].valid) begin
          inv_found = 1'b1;
          inv_w     = WiW'(w);
        end
      end
    end
  end

  // Oldest stamp among the ways in use; the left (lower) way wins ties.
  node_t node [2*TreeP];
  logic [WiW-1:0] lru_w;

  always_comb begin
    node[0] = '0;
    for (int w = 0; w < TreeP; w++) begin
      node[TreeP+w].en  = (w < WAYS) && (w < int'(nw));
      node[TreeP+w].ord = (w < WAYS) ? rd_q[w % WAYS].order : '0;
      node[TreeP+w].idx = WiW'(w);
    end
    for (int i = TreeP - 1; i >= 1; i--) begin
      if (!node[2*i+1].en || (node[2*i].en && node[2*i].ord <= node[2*i+1].ord)) begin
        node[i] = node[2*i];
      end else begin
        node[i] = node[2*i+1];
      end
    end
    lru_w = node[1].idx;
  end

  // Randomizer step and one slice of the modulo reduction.
  logic [LfsrW-1:0] lfsr_nx;
  logic [RemW-1:0]  rem_nx;

  assign lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LfsrW-1:1]};

  always_comb begin
    rem_nx = rem_q;
    for (int k = 0; k < ModStep; k++) begin
      rem_nx = {rem_nx[RemW-2:0], modx_q[LfsrW-1-k]};
      if (rem_nx >= RemW'(nw)) rem_nx = rem_nx - RemW'(nw);
    end
  end

  logic need_mod;
  assign need_mod = !err_q && !hit && !(cmd_q == CMD_WRITE && cfg_wp_q == WP_WT)
                    && !inv_found && (nw != NwW'(1)) && (cfg_pol_q >= POL_RANDOM);

  // Line update and result of the access.
  logic [WiW-1:0]    alloc_w;
  line_t             ln;
  line_t [WAYS-1:0]  fin_row;
  logic              fin_we;
  result_t           fin_res;
  logic [AddrW-1:0]  fin_way32;
  logic [WiW-1:0]    fin_way;

  always_comb begin
    if (inv_found)                    alloc_w = inv_w;
    else if (nw == NwW'(1))           alloc_w = '0;
    else if (cfg_pol_q < POL_RANDOM)  alloc_w = lru_w;
    else                              alloc_w = rem_nx[WiW-1:0];

    fin_row = rd_q;
    fin_we  = 1'b0;
    fin_way = '0;
    ln      = '0;
    fin_res = '0;
    fin_res.error     = err_q;
    fin_res.set_index = set_q[SetOutW-1:0];
    fin_res.tag_value = tag_q;

    if (err_q) begin
      fin_we = 1'b0;
    end else if (hit) begin
      ln = rd_q[hit_w];
      if (cfg_pol_q == POL_LRU) ln.order = cnt_q;
      if (cmd_q == CMD_WRITE) begin
        if (cfg_wp_q == WP_WT) fin_res.mem_write_valid = 1'b1;
        else                   ln.dirty = 1'b1;
      end
      fin_row[hit_w]     = ln;
      fin_we             = 1'b1;
      fin_way            = hit_w;
      fin_res.hit        = 1'b1;
      fin_res.line_dirty = ln.dirty;
    end else if (cmd_q == CMD_WRITE && cfg_wp_q == WP_WT) begin
      // Write-through miss goes straight to memory without allocating.
      fin_res.mem_write_valid = 1'b1;
    end else begin
      ln = rd_q[alloc_w];
      if (!inv_found && ln.dirty) begin
        fin_res.writeback_valid = 1'b1;
        fin_res.writeback_addr  = ((ln.tag << ib_eff) | AddrW'(set_q)) << cfg_ob_q;
      end
      ln.valid = 1'b1;
      ln.tag   = tag_q;
      if (cfg_pol_q < POL_RANDOM) ln.order = cnt_q;
      ln.dirty = (cmd_q == CMD_WRITE);
      fin_row[alloc_w]   = ln;
      fin_we             = 1'b1;
      fin_way            = alloc_w;
      fin_res.fill_valid = 1'b1;
      fin_res.line_dirty = ln.dirty;
    end
    fin_way32   = AddrW'(fin_way);
    fin_res.way = fin_way32[WayOutW-1:0];
  end

  logic do_fin;
  assign do_fin = ((state_q == ST_LOOK) && !need_mod)
               || ((state_q == ST_MOD) && (mcnt_q == McW'(ModCycles - 1)));

  // Memory port.
  logic               mem_we;
  logic [SaW-1:0]     mem_waddr;
  line_t [WAYS-1:0]   mem_wdata;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = do_fin && fin_we;
      mem_waddr = SaW'(set_q);
      mem_wdata = fin_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) set_mem[mem_waddr] <= mem_wdata;
    if (accept) rd_q <= set_mem[SaW'(acc_set[SetW-1:0])];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ob_q   <= RST_OFFSET_BITS;
      cfg_ib_q   <= RST_INDEX_BITS;
      cfg_ways_q <= RST_WAYS_USED;
      cfg_pol_q  <= POL_LRU;
      cfg_wp_q   <= WP_WB;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET_BITS:    cfg_ob_q   <= cfg_data_i[2:0];
        CFG_INDEX_BITS:     cfg_ib_q   <= cfg_data_i[2:0];
        CFG_WAYS_USED:      cfg_ways_q <= cfg_data_i;
        CFG_REPLACE_POLICY: cfg_pol_q  <= cfg_data_i[1:0];
        CFG_WRITE_POLICY:   cfg_wp_q   <= cfg_data_i[0];
        default:            cfg_wp_q   <= cfg_wp_q;
      endcase
    end
  end

  // Sequencer, access registers and result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cmd_q   <= CMD_READ;
      err_q   <= 1'b0;
      set_q   <= '0;
      tag_q   <= '0;
      cnt_q   <= '0;
      lfsr_q  <= LFSR_SEED;
      modx_q  <= '0;
      rem_q   <= '0;
      mcnt_q  <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= do_fin;
      if (do_fin) res_q <= fin_res;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + SaW'(1);
          if (clr_q == SaW'(SETS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_i;
            err_q   <= acc_err;
            set_q   <= acc_set[SetW-1:0];
            tag_q   <= acc_tag;
            cnt_q   <= cnt_q + StampW'(1);
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (need_mod) begin
            lfsr_q  <= lfsr_nx;
            modx_q  <= lfsr_nx;
            rem_q   <= '0;
            mcnt_q  <= '0;
            state_q <= ST_MOD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_MOD: begin
          modx_q <= modx_q << ModStep;
          rem_q  <= rem_nx;
          mcnt_q <= mcnt_q + McW'(1);
          if (mcnt_q == McW'(ModCycles - 1)) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o            = done_q;
  assign hit_o             = res_q.hit;
  assign error_o           = res_q.error;
  assign way_o             = res_q.way;
  assign set_index_o       = res_q.set_index;
  assign tag_value_o       = res_q.tag_value;
  assign line_dirty_o      = res_q.line_dirty;
  assign writeback_valid_o = res_q.writeback_valid;
  assign writeback_addr_o  = res_q.writeback_addr;
  assign fill_valid_o      = res_q.fill_valid;
  assign mem_write_valid_o = res_q.mem_write_valid;

endmodule

`default_nettype wire

[tb/set_assoc_cache_tag_controller_tb.sv]
// Self-checking testbench for the set-associative cache tag controller.
module set_assoc_cache_tag_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import satc_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int MaxIndex  = $clog2(DefSets);

  // Mirror of the tag, valid, dirty and order state plus the queue of awaited results.
  class cache_tag_board;
    localparam int Sets  = DefSets;
    localparam int Ways  = DefWays;
    localparam int Lines = Sets * Ways;

    bit                line_vld [Lines];
    bit                line_drt [Lines];
    logic [TagW-1:0]   line_tags [Lines];
    logic [StampW-1:0] line_stamps [Lines];
    logic [StampW-1:0] accesses;
    logic [LfsrW-1:0]  lfsr;
    logic [2:0]        offset_bits;
    logic [2:0]        index_bits;
    logic [3:0]        ways_used;
    logic [1:0]        repl_pol;
    logic              wr_pol;
    result_t           awaited_results[$];
    int                mismatches;
    int                beats;

    function new();
      foreach (line_vld[i]) begin
        line_vld[i] = 1'b0;
        line_drt[i] = 1'b0;
        line_tags[i] = '0;
        line_stamps[i] = '0;
      end
      accesses = '0;
      lfsr = LFSR_SEED;
      offset_bits = RST_OFFSET_BITS;
      index_bits = RST_INDEX_BITS;
      ways_used = RST_WAYS_USED;
      repl_pol = POL_LRU;
      wr_pol = WP_WB;
      mismatches = 0;
      beats = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_OFFSET_BITS:    offset_bits = val[2:0];
        CFG_INDEX_BITS:     index_bits = val[2:0];
        CFG_WAYS_USED:      ways_used = val;
        CFG_REPLACE_POLICY: repl_pol = val[1:0];
        CFG_WRITE_POLICY:   wr_pol = val[0];
        default: ;
      endcase
    endfunction

    // Works out the result beat of one accepted access and updates the mirrored lines.
    function void predict_access(logic c, logic [AddrW-1:0] a, logic [SizeW-1:0] s);
      result_t     r;
      int unsigned ob, ib, nw, blk, off, setn, base, victim, w, ln;
      logic [StampW-1:0] oldest;
      logic [TagW-1:0]   tg;
      bit          hit;
      ob = offset_bits;
      ib = index_bits;
      nw = ways_used;
      while (ib > 0 && (1 << ib) > Sets) ib--;
      if (nw == 0) nw = 1;
      if (nw > Ways) nw = Ways;
      blk = 1 << ob;
      off = a & (blk - 1);
      setn = (a >> ob) & ((1 << ib) - 1);
      tg = a >> (ob + ib);
      base = setn * Ways;
      accesses++;
      r = '0;
      r.set_index = setn[SetOutW-1:0];
      r.tag_value = tg;
      if (blk - off < s) begin
        // Crossing the block end changes nothing but the access count.
        r.error = 1'b1;
        awaited_results.push_back(r);
        return;
      end
      hit = 1'b0;
      victim = 0;
      for (w = 0; w < nw; w++) begin
        if (line_vld[base + w] && line_tags[base + w] == tg) begin
          hit = 1'b1;
          victim = w;
          break;
        end
      end
      if (hit) begin
        ln = base + victim;
        if (repl_pol == POL_LRU) line_stamps[ln] = accesses;
        if (c == CMD_WRITE) begin
          if (wr_pol == WP_WT) r.mem_write_valid = 1'b1;
          else line_drt[ln] = 1'b1;
        end
        r.hit = 1'b1;
        r.way = victim[WayOutW-1:0];
        r.line_dirty = line_drt[ln];
      end else if (c == CMD_WRITE && wr_pol == WP_WT) begin
        r.mem_write_valid = 1'b1;
      end else begin
        victim = nw;
        for (w = 0; w < nw; w++) begin
          if (!line_vld[base + w]) begin
            victim = w;
            break;
          end
        end
        if (victim == nw) begin
          if (nw == 1) begin
            victim = 0;
          end else if (repl_pol == POL_LRU || repl_pol == POL_FIFO) begin
            victim = 0;
            oldest = line_stamps[base];
            for (w = 1; w < nw; w++) begin
              if (line_stamps[base + w] < oldest) begin
                oldest = line_stamps[base + w];
                victim = w;
              end
            end
          end else begin
            lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LfsrW-1:1]};
            victim = lfsr % nw;
          end
          ln = base + victim;
          if (line_drt[ln]) begin
            r.writeback_valid = 1'b1;
            r.writeback_addr = ((line_tags[ln] << ib) | setn) << ob;
            line_drt[ln] = 1'b0;
          end
        end
        ln = base + victim;
        line_vld[ln] = 1'b1;
        line_tags[ln] = tg;
        r.fill_valid = 1'b1;
        if (repl_pol == POL_LRU || repl_pol == POL_FIFO) line_stamps[ln] = accesses;
        line_drt[ln] = (c == CMD_WRITE);
        r.way = victim[WayOutW-1:0];
        r.line_dirty = line_drt[ln];
      end
      awaited_results.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH beat %0d: %s", beats, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      beats++;
      if (awaited_results.size() == 0) begin
        report($sformatf("result beat with nothing awaited, tag %0h", got.tag_value));
        return;
      end
      want = awaited_results.pop_front();
      compare_field("hit", 32'(got.hit), 32'(want.hit));
      compare_field("error", 32'(got.error), 32'(want.error));
      compare_field("way", 32'(got.way), 32'(want.way));
      compare_field("set_index", 32'(got.set_index), 32'(want.set_index));
      compare_field("tag_value", got.tag_value, want.tag_value);
      compare_field("line_dirty", 32'(got.line_dirty), 32'(want.line_dirty));
      compare_field("writeback_valid", 32'(got.writeback_valid),
                    32'(want.writeback_valid));
      compare_field("writeback_addr", got.writeback_addr, want.writeback_addr);
      compare_field("fill_valid", 32'(got.fill_valid), 32'(want.fill_valid));
      compare_field("mem_write_valid", 32'(got.mem_write_valid),
                    32'(want.mem_write_valid));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                cmd_i;
  logic [AddrW-1:0]    addr_i;
  logic [SizeW-1:0]    size_i;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                done_o;
  logic                hit_o;
  logic                error_o;
  logic [WayOutW-1:0]  way_o;
  logic [SetOutW-1:0]  set_index_o;
  logic [TagW-1:0]     tag_value_o;
  logic                line_dirty_o;
  logic                writeback_valid_o;
  logic [AddrW-1:0]    writeback_addr_o;
  logic                fill_valid_o;
  logic                mem_write_valid_o;

  cache_tag_board sb;
  result_t        seen;
  int             idle_cycles = 0;

  // Geometry the address generator aims at, and the tags it draws from.
  int unsigned    gen_ob = RST_OFFSET_BITS;
  int unsigned    gen_ib = RST_INDEX_BITS;
  int unsigned    gen_nw = RST_WAYS_USED;
  logic [TagW-1:0] tag_pool [11];

  set_assoc_cache_tag_controller dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Everything is sampled at the rising edge, before this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        seen.hit = hit_o;
        seen.error = error_o;
        seen.way = way_o;
        seen.set_index = set_index_o;
        seen.tag_value = tag_value_o;
        seen.line_dirty = line_dirty_o;
        seen.writeback_valid = writeback_valid_o;
        seen.writeback_addr = writeback_addr_o;
        seen.fill_valid = fill_valid_o;
        seen.mem_write_valid = mem_write_valid_o;
        sb.check_result(seen);
      end
      if (start && !busy) sb.predict_access(cmd_i, addr_i, size_i);
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (done_o || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no beat for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic drive_access(input logic c, input logic [AddrW-1:0] a,
                              input logic [SizeW-1:0] s);
    start <= 1'b1;
    cmd_i <= c;
    addr_i <= a;
    size_i <= s;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops sending and waits until every awaited result beat has come.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic refresh_tags();
    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
  endtask

  // Bits above each register's width carry junk, which the block must drop.
  task automatic apply_setting(input logic [2:0] ob, input logic [2:0] ib,
                               input logic [3:0] ways, input logic [1:0] rp,
                               input logic wp);
    logic [CfgIdxW-1:0]  idx_list [5];
    logic [CfgDataW-1:0] vals [5];
    logic [3:0]          junk;
    junk = 4'($urandom);
    idx_list = '{CFG_OFFSET_BITS, CFG_INDEX_BITS, CFG_WAYS_USED, CFG_REPLACE_POLICY,
                 CFG_WRITE_POLICY};
    vals = '{{junk[0], ob}, {junk[1], ib}, ways, {junk[3:2], rp}, {junk[3:1], wp}};
    while (busy) @(posedge clk_i);
    foreach (idx_list[k]) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx_list[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
    end
    // An index past the last register must be ignored.
    cfg_idx_i <= CFG_WRITE_POLICY + 3'($urandom_range(1, 3));
    cfg_data_i <= CfgDataW'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_ob = ob;
    gen_ib = (ib > MaxIndex) ? MaxIndex : ib;
    gen_nw = (ways == 0) ? 1 : (ways > DefWays) ? DefWays : ways;
    refresh_tags();
  endtask

  // Mostly well-formed accesses into a few sets with a small tag pool, so
  // that sets fill, hit and evict; the rest is unconstrained noise.
  task automatic run_random(input int count);
    int unsigned blk, off, setn, burst, gap;
    logic        c;
    logic [AddrW-1:0] a;
    logic [SizeW-1:0] s;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25) : $urandom_range(0, 2);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 40);
      end
      burst--;
      if ($urandom_range(0, 99) < 12) begin
        c = 1'($urandom);
        a = $urandom;
        s = SizeW'($urandom_range(0, 15));
      end else begin
        blk = 1 << gen_ob;
        s = SizeW'($urandom_range(0, (blk < 8) ? blk : 8));
        off = $urandom_range(0, blk - s);
        if ($urandom_range(0, 3) == 0) setn = $urandom_range(0, (1 << gen_ib) - 1);
        else setn = $urandom_range(0, ((1 << gen_ib) > 4) ? 3 : (1 << gen_ib) - 1);
        a = (tag_pool[$urandom_range(0, gen_nw + 2)] << (gen_ob + gen_ib))
            | (setn << gen_ob) | off;
        c = ($urandom_range(0, 9) < 4) ? CMD_WRITE : CMD_READ;
      end
      drive_access(c, a, s);
      if ($urandom_range(0, 99) == 0) settle();
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = CMD_READ;
    addr_i = '0;
    size_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OFFSET_BITS;
    cfg_data_i = '0;
    refresh_tags();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: 16-byte blocks and 64 sets, so the tag starts at bit 10.
    drive_access(CMD_READ, 32'h0, 4);
    drive_access(CMD_WRITE, 32'h0, 8);
    drive_access(CMD_WRITE, 32'h8, 9);
    drive_access(CMD_READ, 32'hF, 0);
    drive_access(CMD_WRITE, 32'hFFFF_FFFF, 1);
    drive_access(CMD_READ, 32'hFFFF_FFFE, 15);
    drive_access(CMD_READ, 32'hFFFF_FFF0, 15);
    for (int k = 1; k < 8; k++) drive_access(CMD_WRITE, k << 10, 4);
    // Way 0 becomes most recent, so the next two misses evict dirty ways 1 and 2.
    drive_access(CMD_READ, 32'h0, 1);
    drive_access(CMD_READ, 8 << 10, 2);
    drive_access(CMD_READ, 9 << 10, 2);
    run_random(140);

    settle();
    apply_setting(3'd0, 3'd0, 4'd1, POL_FIFO, WP_WB);
    run_random(150);
    settle();
    apply_setting(3'd7, 3'd7, 4'd15, POL_RANDOM, WP_WB);
    run_random(150);
    settle();
    apply_setting(3'd2, 3'd3, 4'd4, POL_RANDOM + 2'd1, WP_WT);
    run_random(150);
    settle();
    apply_setting(3'd6, 3'd2, 4'd0, POL_LRU, WP_WT);
    run_random(150);
    settle();
    apply_setting(3'd3, 3'd1, 4'd3, POL_FIFO, WP_WB);
    run_random(150);
    settle();
    apply_setting(3'd5, 3'd4, 4'd8, POL_RANDOM, WP_WT);
    run_random(150);
    settle();
    apply_setting(3'd1, 3'd6, 4'd9, POL_LRU, WP_WB);
    run_random(150);
    settle();
    apply_setting(3'd0, 3'd5, 4'd2, POL_RANDOM, WP_WB);
    run_random(150);
    for (int p = 0; p < 2; p++) begin
      settle();
      apply_setting(3'($urandom), 3'($urandom), 4'($urandom), 2'($urandom),
                    1'($urandom));
      run_random(150);
    end

    settle();
    if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
